/* src/ntpcal_pkg.sv */
// Shared widths, types and calendar helpers for the NTP seconds to calendar block.
`timescale 1ns / 1ps

package ntpcal_pkg;

  localparam int unsigned SecondsW = 32;
  localparam int unsigned BiasW    = 11;
  localparam int unsigned SecW     = 6;
  localparam int unsigned HourW    = 5;
  localparam int unsigned YearW    = 8;
  localparam int unsigned YdayW    = 9;
  localparam int unsigned MonW     = 4;
  localparam int unsigned MdayW    = 5;
  localparam int unsigned WdayW    = 3;
  localparam int unsigned DayW     = 16;
  localparam int unsigned DivisorW = 6;

  localparam logic [DivisorW-1:0] SecPerMin  = 6'd60;
  localparam logic [DivisorW-1:0] MinPerHour = 6'd60;
  localparam logic [DivisorW-1:0] HourPerDay = 6'd24;
  localparam logic [DivisorW-1:0] DayPerWeek = 6'd7;

  // Truncated reciprocals 2^32 / d; the estimate they give is low by at most one.
  localparam logic [SecondsW-1:0] RecipSixty =
      SecondsW'((64'd1 << SecondsW) / 64'(SecPerMin));
  localparam logic [SecondsW-1:0] RecipHourPerDay =
      SecondsW'((64'd1 << SecondsW) / 64'(HourPerDay));
  localparam logic [SecondsW-1:0] RecipDayPerWeek =
      SecondsW'((64'd1 << SecondsW) / 64'(DayPerWeek));

  localparam logic [MonW-1:0]  LastMonth  = 4'd11;
  localparam logic [MonW-1:0]  February   = 4'd1;
  localparam logic [YearW-1:0] Year1900   = 8'd0;
  localparam logic [YearW-1:0] Year2100   = 8'd200;

  typedef struct packed {
    logic                start;
    logic [SecondsW-1:0] dividend;
    logic [DivisorW-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                done;
    logic [SecondsW-1:0] quotient;
    logic [DivisorW-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic             done;
    logic [YearW-1:0] year;
    logic [YdayW-1:0] yday;
    logic [MonW-1:0]  mon;
    logic [MdayW-1:0] mday;
  } walk_rsp_t;

  // Years are counted from 1900; within 0..255 only 1900 and 2100 are
  // century years that are not leap years.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != Year1900) && (y != Year2100);
  endfunction

  function automatic logic [MdayW-1:0] month_len(input logic [MonW-1:0] m,
                                                 input logic leap);
    logic [MdayW-1:0] len;
    case (m)
      4'd0:     len = 5'd31;
      February: len = leap ? 5'd29 : 5'd28;
      4'd2:     len = 5'd31;
      4'd3:     len = 5'd30;
      4'd4:     len = 5'd31;
      4'd5:     len = 5'd30;
      4'd6:     len = 5'd31;
      4'd7:     len = 5'd31;
      4'd8:     len = 5'd30;
      4'd9:     len = 5'd31;
      4'd10:    len = 5'd30;
      4'd11:    len = 5'd31;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/ntpcal_if.sv */
// Valid/ready channel interfaces for the timestamp input and the date output.
`timescale 1ns / 1ps

interface ntpcal_in_if import ntpcal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SecondsW-1:0] ntp_seconds;

  modport source (output valid, output ntp_seconds, input ready);
  modport sink   (input valid, input ntp_seconds, output ready);
endinterface

interface ntpcal_out_if import ntpcal_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SecW-1:0]  second;
  logic [SecW-1:0]  minute;
  logic [HourW-1:0] hour;
  logic [YearW-1:0] year_since_1900;
  logic [YdayW-1:0] day_of_year;
  logic [MonW-1:0]  month;
  logic [MdayW-1:0] day_of_month;
  logic [WdayW-1:0] weekday;

  modport source (output valid, output second, output minute, output hour,
                  output year_since_1900, output day_of_year, output month,
                  output day_of_month, output weekday, input ready);
  modport sink   (input valid, input second, input minute, input hour,
                  input year_since_1900, input day_of_year, input month,
                  input day_of_month, input weekday, output ready);
endinterface

/* src/ntpcal_div.sv */
// Divider of a 32-bit value by a small constant through a shared reciprocal multiplier.
`timescale 1ns / 1ps

module ntpcal_div import ntpcal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_REM,
    D_FIX
  } div_state_e;

  div_state_e                   state_q;
  logic [SecondsW-1:0]          dividend_q;
  logic [DivisorW-1:0]          divisor_q;
  logic [SecondsW-1:0]          recip_q;
  logic [2*SecondsW-1:0]        prod_q;
  logic [SecondsW-1:0]          quot_q;
  logic [DivisorW:0]            rem_q;
  logic                         done_q;
  logic [SecondsW-1:0]          recip;
  logic [SecondsW-1:0]          quot_est;
  logic [SecondsW+DivisorW-1:0] back_prod;
  logic [SecondsW-1:0]          rem_full;
  logic                         over;

  always_comb begin
    case (cmd_i.divisor)
      HourPerDay: recip = RecipHourPerDay;
      DayPerWeek: recip = RecipDayPerWeek;
      // Seconds per minute and minutes per hour are both sixty.
      default:    recip = RecipSixty;
    endcase
    quot_est  = prod_q[2*SecondsW-1:SecondsW];
    back_prod = quot_est * divisor_q;
    rem_full  = dividend_q - back_prod[SecondsW-1:0];
    over      = rem_q >= {1'b0, divisor_q};
  end

  // The estimate is the true quotient or one below it, so one correction step ends it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= D_IDLE;
      dividend_q <= '0;
      divisor_q  <= '0;
      recip_q    <= '0;
      prod_q     <= '0;
      quot_q     <= '0;
      rem_q      <= '0;
      done_q     <= 1'b0;
    end else begin
      case (state_q)
        D_IDLE: begin
          done_q <= 1'b0;
          if (cmd_i.start) begin
            dividend_q <= cmd_i.dividend;
            divisor_q  <= cmd_i.divisor;
            recip_q    <= recip;
            state_q    <= D_MUL;
          end
        end
        D_MUL: begin
          prod_q  <= dividend_q * recip_q;
          state_q <= D_REM;
        end
        D_REM: begin
          quot_q  <= quot_est;
          rem_q   <= rem_full[DivisorW:0];
          state_q <= D_FIX;
        end
        D_FIX: begin
          if (over) begin
            quot_q <= quot_q + 1'b1;
            rem_q  <= rem_q - {1'b0, divisor_q};
          end
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quot_q;
  assign rsp_o.remainder = rem_q[DivisorW-1:0];

endmodule

/* src/ntpcal_walk.sv */
// Walks a day count over years and then months to give the Gregorian date.
`timescale 1ns / 1ps

module ntpcal_walk import ntpcal_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DayW-1:0] days_i,
  output walk_rsp_t       rsp_o
);

  typedef enum logic [1:0] {
    W_IDLE,
    W_YEAR,
    W_MON
  } walk_state_e;

  walk_state_e      state_q;
  logic [DayW-1:0]  rem_q;
  logic [YearW-1:0] year_q;
  logic [YdayW-1:0] yday_q;
  logic [MonW-1:0]  mon_q;
  logic             done_q;
  logic             leap;
  logic [YdayW-1:0] ylen;
  logic [MdayW-1:0] mlen;

  always_comb begin
    leap = is_leap(year_q);
    ylen = leap ? 9'd366 : 9'd365;
    mlen = month_len(mon_q, leap);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
      rem_q   <= '0;
      year_q  <= '0;
      yday_q  <= '0;
      mon_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        W_IDLE: begin
          if (start_i) begin
            rem_q   <= days_i;
            year_q  <= '0;
            mon_q   <= '0;
            state_q <= W_YEAR;
          end
        end
        W_YEAR: begin
          if (rem_q < DayW'(ylen)) begin
            // The remainder is now the day of the year.
            yday_q  <= rem_q[YdayW-1:0];
            state_q <= W_MON;
          end else begin
            rem_q  <= rem_q - DayW'(ylen);
            year_q <= year_q + 1'b1;
          end
        end
        W_MON: begin
          if (mon_q == LastMonth || rem_q < DayW'(mlen)) begin
            done_q  <= 1'b1;
            state_q <= W_IDLE;
          end else begin
            rem_q <= rem_q - DayW'(mlen);
            mon_q <= mon_q + 1'b1;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.year = year_q;
  assign rsp_o.yday = yday_q;
  assign rsp_o.mon  = mon_q;
  assign rsp_o.mday = rem_q[MdayW-1:0] + 1'b1;

endmodule

/* src/ntp_seconds_to_calendar.sv */
// Converts NTP era-0 seconds to local Gregorian calendar fields.
//
// Input channel in_i carries one 32-bit seconds count per beat; output
// channel out_o returns one beat per input with second, minute, hour, year
// since 1900, day of year, month, day of month and weekday (Sunday is 0).
// The time-zone bias in minutes is written through cfg_we_i / cfg_wdata_i and
// is subtracted, times 60, with 32-bit wraparound before the conversion.
// One beat is worked on at a time: in_i.ready is high only while the
// sequencer is idle. After acceptance it makes four passes of the shared
// reciprocal divider (by 60, 60, 24 and 7), then runs the year walk one
// year at a time and the month walk one month at a time. The next beat
// can be accepted in the cycle after the result is loaded.
// The result sits in an output register, so a new beat is accepted while the
// previous result still waits; if the receiver stalls until the next result
// is ready, the sequencer holds until the register frees up.
// Reset clears the bias to zero and empties the pipeline.
`timescale 1ns / 1ps

module ntp_seconds_to_calendar import ntpcal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BiasW-1:0] cfg_wdata_i,
  ntpcal_in_if.sink        in_i,
  ntpcal_out_if.source     out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_HOUR,
    S_WDAY,
    S_WALK,
    S_HOLD
  } seq_state_e;

  seq_state_e          state_q;
  logic [BiasW-1:0]    bias_q;
  logic [SecondsW-1:0] bias_ext;
  logic [SecondsW-1:0] bias_sec;
  logic [SecondsW-1:0] local_sec;
  logic [SecW-1:0]     sec_q;
  logic [SecW-1:0]     min_q;
  logic [HourW-1:0]    hour_q;
  logic [WdayW-1:0]    wday_q;
  logic [DayW-1:0]     days_q;
  logic                walk_start_q;
  div_cmd_t            div_cmd_q;
  div_rsp_t            div_rsp;
  walk_rsp_t           walk_rsp;
  logic                out_valid_q;
  logic                out_free;
  logic                out_load;
  logic                accept;

  // Bias times 60 as (b << 6) - (b << 2), sign-extended to the full width.
  always_comb begin
    bias_ext  = {{(SecondsW-BiasW){bias_q[BiasW-1]}}, bias_q};
    bias_sec  = (bias_ext << 6) - (bias_ext << 2);
    local_sec = in_i.ntp_seconds - bias_sec;
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = (state_q == S_HOLD || (state_q == S_WALK && walk_rsp.done)) &&
                      out_free;

  ntpcal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd_q),
    .rsp_o  (div_rsp)
  );

  ntpcal_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start_q),
    .days_i  (days_q),
    .rsp_o   (walk_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
    end else if (cfg_we_i) begin
      bias_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= S_IDLE;
      div_cmd_q             <= '0;
      walk_start_q          <= 1'b0;
      out_valid_q           <= 1'b0;
      sec_q                 <= '0;
      min_q                 <= '0;
      hour_q                <= '0;
      wday_q                <= '0;
      days_q                <= '0;
      out_o.second          <= '0;
      out_o.minute          <= '0;
      out_o.hour            <= '0;
      out_o.year_since_1900 <= '0;
      out_o.day_of_year     <= '0;
      out_o.month           <= '0;
      out_o.day_of_month    <= '0;
      out_o.weekday         <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            div_cmd_q <= '{start: 1'b1, dividend: local_sec, divisor: SecPerMin};
            state_q   <= S_SEC;
          end else begin
            div_cmd_q.start <= 1'b0;
          end
        end
        S_SEC: begin
          if (div_rsp.done) begin
            sec_q     <= div_rsp.remainder;
            div_cmd_q <= '{start: 1'b1, dividend: div_rsp.quotient,
                           divisor: MinPerHour};
            state_q   <= S_MIN;
          end else begin
            div_cmd_q.start <= 1'b0;
          end
        end
        S_MIN: begin
          if (div_rsp.done) begin
            min_q     <= div_rsp.remainder;
            div_cmd_q <= '{start: 1'b1, dividend: div_rsp.quotient,
                           divisor: HourPerDay};
            state_q   <= S_HOUR;
          end else begin
            div_cmd_q.start <= 1'b0;
          end
        end
        S_HOUR: begin
          if (div_rsp.done) begin
            hour_q    <= div_rsp.remainder[HourW-1:0];
            days_q    <= div_rsp.quotient[DayW-1:0];
            // 1900-01-01 was a Monday, so the weekday is (days + 1) mod 7.
            div_cmd_q <= '{start: 1'b1,
                           dividend: div_rsp.quotient + 1'b1,
                           divisor: DayPerWeek};
            state_q   <= S_WDAY;
          end else begin
            div_cmd_q.start <= 1'b0;
          end
        end
        S_WDAY: begin
          if (div_rsp.done) begin
            wday_q       <= div_rsp.remainder[WdayW-1:0];
            walk_start_q <= 1'b1;
            state_q      <= S_WALK;
          end else begin
            div_cmd_q.start <= 1'b0;
          end
        end
        S_WALK, S_HOLD: begin
          walk_start_q <= 1'b0;
          if (out_load) begin
            out_o.second          <= sec_q;
            out_o.minute          <= min_q;
            out_o.hour            <= hour_q;
            out_o.year_since_1900 <= walk_rsp.year;
            out_o.day_of_year     <= walk_rsp.yday;
            out_o.month           <= walk_rsp.mon;
            out_o.day_of_month    <= walk_rsp.mday;
            out_o.weekday         <= wday_q;
            state_q               <= S_IDLE;
          end else if (walk_rsp.done) begin
            state_q <= S_HOLD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_valid_q;

endmodule
